/* sv/lzrd_pkg.sv */
`default_nettype none

package lzrd_pkg;

  // Geometry of the token format.
  localparam int unsigned START_GAP = 18;      // stream starts this far before the ring end
  localparam int unsigned MIN_MATCH = 3;       // shortest match length
  localparam logic [7:0]  FILL_BYTE = 8'h20;   // value of a ring entry not yet written
  localparam int unsigned CNT_W     = 5;       // remaining-bytes counter of a match

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DEC  = 5'b00010,
    ST_EMIT = 5'b00100,
    ST_RD   = 5'b01000,
    ST_WR   = 5'b10000
  } state_e;

  // What the held input byte is, given the token state.
  typedef enum logic [1:0] {
    KIND_FLAG  = 2'd0,
    KIND_LOW   = 2'd1,
    KIND_LIT   = 2'd2,
    KIND_MATCH = 2'd3
  } kind_e;

  typedef struct packed {
    logic capture;   // latch the accepted input byte
    logic dec_en;    // update token state from the held byte
    logic emit_en;   // load output with a literal or a bare end marker
    logic rd_en;     // issue a ring read for the next match byte
    logic wr_en;     // write back the copied byte and load output
    logic restart;   // return stream state to its start values
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  last;         // held byte ends the stream
    logic  match_final;  // current match byte is the last one
    logic  out_free;     // output register can take a new transaction
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/lzss_ring_decoder.sv */
`default_nettype none

// Channel   Direction  Signals                 Contents
// s_axis    in         tvalid/tready/tdata     tdata[7:0] compressed byte
//                      tlast                   final byte of the stream
// m_axis    out        tvalid/tready/tdata     tdata[7:0] decoded byte (0 on a bare marker)
//                      tlast                   last result caused by one input byte
//                      tuser[1:0]              [0] has data, [1] end of stream
//
// One input transaction is handled at a time: a flag or match low byte is decoded and, when it
// ends the stream, a bare marker is emitted; a literal is decoded and emitted; a match high byte
// copies 3 to 18 bytes, each needing a ring read and then a write back through the registered RAM.
// Reset is asynchronous and active low; the ring is not cleared, and a count of the writes
// in the current stream makes unwritten entries read as space.
// A stalled output holds the result register, and the decoder waits until it drains.

module lzss_ring_decoder #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output      logic       s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output      logic [1:0] m_axis_tuser_o,   // [0] has_data, [1] stream_done
  output      logic       m_axis_tlast_o
);
  import lzrd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  state_e     state;

  // The controller sequences decode, emit and the read/write steps of a match copy.
  lzrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // The datapath holds the token state, the ring, the write pointer and the output register.
  lzrd_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_byte_i      (s_axis_tdata_i),
    .in_last_i      (s_axis_tlast_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_byte_o     (m_axis_tdata_o),
    .out_has_data_o (m_axis_tuser_o[0]),
    .out_run_last_o (m_axis_tlast_o),
    .out_done_o     (m_axis_tuser_o[1])
  );

  // Input is only taken while no item is being worked on.
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state != ST_IDLE) |-> !s_axis_tready_o)
    else $error("input accepted while an item is in progress");

  // The end of a stream always closes the run of its input byte.
  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tlast_o)
    else $error("end of stream without run end");

  // A bare end marker carries a zero byte and ends the stream.
  a_bare_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |->
      (m_axis_tdata_o == 8'h00) && m_axis_tuser_o[1])
    else $error("bare marker malformed");

  // A new result is loaded only when the previous one has been taken.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_en || cmd.wr_en) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten");

endmodule

`default_nettype wire

/* sv/lzrd_ram.sv */
`default_nettype none

module lzrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/lzrd_ctrl.sv */
`default_nettype none

module lzrd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire lzrd_pkg::dp_status_t status_i,
  output      lzrd_pkg::ctrl_cmd_t  cmd_o,
  output      lzrd_pkg::state_e     state_o
);
  import lzrd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd_o.dec_en = 1'b1;
        unique case (status_i.kind)
          KIND_FLAG, KIND_LOW: state_d = status_i.last ? ST_EMIT : ST_IDLE;
          KIND_LIT:            state_d = ST_EMIT;
          KIND_MATCH:          state_d = ST_RD;
          default:             state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          cmd_o.restart = status_i.last;
          state_d       = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WR;
      end
      ST_WR: begin
        if (status_i.out_free) begin
          cmd_o.wr_en = 1'b1;
          if (status_i.match_final) begin
            cmd_o.restart = status_i.last;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

/* sv/lzrd_dp.sv */
`default_nettype none

module lzrd_dp #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lzrd_pkg::ctrl_cmd_t  cmd_i,
  output      lzrd_pkg::dp_status_t status_o,
  input  wire logic [7:0]           in_byte_i,
  input  wire logic                 in_last_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [7:0]           out_byte_o,
  output      logic                 out_has_data_o,
  output      logic                 out_run_last_o,
  output      logic                 out_done_o
);
  import lzrd_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] StartPos = AW'(RING_DEPTH - START_GAP);

  // Held input transaction.
  logic [7:0] byte_q;
  logic       last_q;

  // Token and ring state.
  logic [AW-1:0]    wpos_q, wpos_d;
  logic [CW-1:0]    wcnt_q, wcnt_d;
  logic [7:0]       flags_q, flags_d;
  logic [3:0]       left_q, left_d;
  logic [7:0]       low_q, low_d;
  logic             await_q, await_d;
  logic             lit_q;

  // Match copy state.
  logic [AW-1:0]    raddr_q;
  logic [CNT_W-1:0] mcnt_q;
  logic             vld_q;

  // Output register.
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       ohas_q, orun_q, odone_q;

  logic [AW-1:0] age;
  logic [7:0]    ram_rdata;
  logic [7:0]    copy_byte;
  logic          ram_we;
  logic [7:0]    ram_wdata;
  kind_e         kind;

  always_comb begin
    if (await_q) begin
      kind = KIND_MATCH;
    end else if (left_q == 4'd0) begin
      kind = KIND_FLAG;
    end else if (flags_q[0]) begin
      kind = KIND_LIT;
    end else begin
      kind = KIND_LOW;
    end
  end

  assign age       = raddr_q - StartPos;
  assign copy_byte = vld_q ? ram_rdata : FILL_BYTE;
  assign ram_we    = cmd_i.wr_en || (cmd_i.emit_en && lit_q);
  assign ram_wdata = cmd_i.wr_en ? copy_byte : byte_q;

  lzrd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    wpos_d  = wpos_q;
    wcnt_d  = wcnt_q;
    flags_d = flags_q;
    left_d  = left_q;
    low_d   = low_q;
    await_d = await_q;
    if (cmd_i.dec_en) begin
      unique case (kind)
        KIND_FLAG: begin
          flags_d = byte_q;
          left_d  = 4'd8;
        end
        KIND_LIT: begin
          flags_d = {1'b0, flags_q[7:1]};
          left_d  = left_q - 4'd1;
        end
        KIND_LOW: begin
          flags_d = {1'b0, flags_q[7:1]};
          left_d  = left_q - 4'd1;
          low_d   = byte_q;
          await_d = 1'b1;
        end
        KIND_MATCH: await_d = 1'b0;
        default:    await_d = 1'b0;
      endcase
    end
    if (ram_we) begin
      wpos_d = wpos_q + AW'(1);
      if (wcnt_q != CW'(RING_DEPTH)) begin
        wcnt_d = wcnt_q + CW'(1);
      end
    end
    if (cmd_i.restart) begin
      wpos_d  = StartPos;
      wcnt_d  = '0;
      flags_d = '0;
      left_d  = '0;
      low_d   = '0;
      await_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= StartPos;
      wcnt_q   <= '0;
      flags_q  <= '0;
      left_q   <= '0;
      low_q    <= '0;
      await_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      wpos_q  <= wpos_d;
      wcnt_q  <= wcnt_d;
      flags_q <= flags_d;
      left_q  <= left_d;
      low_q   <= low_d;
      await_q <= await_d;
      if (cmd_i.emit_en || cmd_i.wr_en) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cmd_i.dec_en) begin
      lit_q   <= (kind == KIND_LIT);
      raddr_q <= AW'({byte_q[7:4], low_q});
      mcnt_q  <= CNT_W'(byte_q[3:0]) + CNT_W'(MIN_MATCH - 1);
    end
    if (cmd_i.rd_en) begin
      // Age of the entry against the writes of this stream so far.
      vld_q   <= ({1'b0, age} < wcnt_q);
      raddr_q <= raddr_q + AW'(1);
    end
    if (cmd_i.wr_en) begin
      mcnt_q  <= mcnt_q - CNT_W'(1);
      obyte_q <= copy_byte;
      ohas_q  <= 1'b1;
      orun_q  <= (mcnt_q == '0);
      odone_q <= (mcnt_q == '0) && last_q;
    end else if (cmd_i.emit_en) begin
      obyte_q <= lit_q ? byte_q : 8'h00;
      ohas_q  <= lit_q;
      orun_q  <= 1'b1;
      odone_q <= last_q;
    end
  end

  assign status_o.kind        = kind;
  assign status_o.last        = last_q;
  assign status_o.match_final = (mcnt_q == '0);
  assign status_o.out_free    = !ovalid_q || out_ready_i;

  assign out_valid_o    = ovalid_q;
  assign out_byte_o     = obyte_q;
  assign out_has_data_o = ohas_q;
  assign out_run_last_o = orun_q;
  assign out_done_o     = odone_q;

endmodule

`default_nettype wire

/* sim/tb_lzss_ring_decoder.sv */
`timescale 1ns / 100ps

// Self-checking bench for the LZSS ring decoder.
//
// Every compressed byte that the decoder takes is run through a local copy of the
// decoder state (ring, write position, written count, flag register, match half)
// at the clock edge of its transaction. The bytes that it produces go into a queue
// and every result transaction is compared with the oldest entry.
//
// The stimulus has two parts:
//   - A short directed table. It holds literal extremes, shortest and longest
//     matches, an overlapping copy that wraps the write position, reads of
//     entries not written in the current stream, and streams that end on a flag
//     byte, on a match low byte, on a literal and on a match high byte.
//   - Many short random streams with random flags, literals, offsets and lengths.
//
// A match may read any ring index. An entry that is not written in the current
// stream reads as space whatever the ring holds, so the bench never needs the
// contents of an entry that the decoder has not written.

module tb_lzss_ring_decoder;
  import lzrd_pkg::*;

  localparam int          RING          = 4096;
  localparam logic [11:0] RING_START    = 12'(RING - START_GAP);
  localparam int          RANDOM_ITEMS  = 357;      // bytes over the short random streams
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          TAIL_CYCLES   = 64;       // longer than one 18-byte match
  localparam int          FROM_PREDICTOR = -1;      // table row with no typed result

  // Idling phases. The phase changes every 48 accepted input transactions.
  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_SINK_STALLS,
    PH_BOTH
  } gap_phase_e;

  // One result transaction as the bench sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       run_last;
    logic       done;
  } beat_t;

  // One row of the directed table. When n_typed is 0 or 1, the row types that many
  // results. Otherwise the predictor works it out.
  typedef struct {
    logic [7:0] code;
    logic       ends;
    int         n_typed;
    logic [7:0] t_data;
    logic       t_has;
    logic       t_done;
  } step_row_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tready = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;   // [7:0] out_byte
  wire  [1:0] m_tuser;   // [0] has_data, [1] stream_done
  wire        m_tlast;

  always #5 clk = ~clk;

  lzss_ring_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Decoder state as the bench tracks it.
  logic [7:0]  hist [RING];
  logic [11:0] wpos;
  logic [12:0] wcount;
  logic [7:0]  flags;
  logic [3:0]  flags_n;
  logic [7:0]  low_byte;
  bit          want_high;

  // Decoded bytes still owed by the decoder, oldest first.
  beat_t       decoded_q [$];

  logic [7:0]  held_high;            // high byte planned together with its low byte
  int unsigned n_sent   = 0;
  int unsigned n_random = 0;
  int unsigned faults   = 0;
  int unsigned cycles   = 0;

  // Directed table. The rows are grouped by stream, and each stream ends on its
  // row with tlast set.
  step_row_t dir_rows [23] = '{
    // Flag byte: three literals, then matches. A flag byte gives no output.
    '{8'h07, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1,              8'h00, 1'b1, 1'b0},
    '{8'hFF, 1'b0, 1,              8'hFF, 1'b1, 1'b0},
    '{8'h41, 1'b0, 1,              8'h41, 1'b1, 1'b0},
    // Longest match from the stream start: an overlapping copy that wraps the
    // write position past the ring end.
    '{8'hEE, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, FROM_PREDICTOR, 8'h00, 1'b0, 1'b0},
    // Shortest match, from ring index zero.
    '{8'h00, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, FROM_PREDICTOR, 8'h00, 1'b0, 1'b0},
    // The stream ends on a match low byte: the half pair is dropped and a bare
    // end marker comes out.
    '{8'h34, 1'b1, 1,              8'h00, 1'b0, 1'b1},
    // A stream that holds only a flag byte.
    '{8'hA5, 1'b1, 1,              8'h00, 1'b0, 1'b1},
    // A match in a fresh stream. Every entry that it reads is stale, so it gives
    // spaces. Then a literal ends the stream.
    '{8'h02, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'hF0, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'hF2, 1'b0, FROM_PREDICTOR, 8'h00, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1,              8'h80, 1'b1, 1'b1},
    // The stream ends on a match high byte.
    '{8'hFE, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'hEE, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'hF0, 1'b1, FROM_PREDICTOR, 8'h00, 1'b0, 1'b0},
    // A literal and then a long overlapping copy that repeats it, and a short
    // match from ring index zero that ends the stream.
    '{8'h01, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'h7E, 1'b0, 1,              8'h7E, 1'b1, 1'b0},
    '{8'hEE, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, FROM_PREDICTOR, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 0,              8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, FROM_PREDICTOR, 8'h00, 1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_stream();
    wpos      = RING_START;
    wcount    = '0;
    flags     = '0;
    flags_n   = '0;
    low_byte  = '0;
    want_high = 1'b0;
  endfunction

  // An entry counts as written only if the current stream has reached it.
  function automatic logic [7:0] hist_fetch(input logic [11:0] idx);
    logic [11:0] age;
    age = idx - RING_START;
    if ({1'b0, age} < wcount) return hist[idx];
    return FILL_BYTE;
  endfunction

  function automatic void hist_store(input logic [7:0] value);
    hist[wpos] = value;
    wpos       = wpos + 12'd1;
    if (wcount < 13'(RING)) wcount = wcount + 13'd1;
  endfunction

  // Applies one accepted compressed byte. When keep is set, its results go into
  // the queue.
  function automatic void decode_token(input logic [7:0] code, input logic ends,
                                       input bit keep);
    beat_t       run [$];
    beat_t       one;
    logic [11:0] src;
    int unsigned span;
    if (want_high) begin
      src       = {code[7:4], low_byte};
      span      = code[3:0] + MIN_MATCH;
      want_high = 1'b0;
      for (int i = 0; i < span; i++) begin
        one = '{hist_fetch(src + 12'(i)), 1'b1, 1'b0, 1'b0};
        hist_store(one.data);
        run.push_back(one);
      end
    end else if (flags_n == 0) begin
      flags   = code;
      flags_n = 4'd8;
    end else begin
      flags_n = flags_n - 4'd1;
      if (flags[0]) begin
        hist_store(code);
        run.push_back('{code, 1'b1, 1'b0, 1'b0});
      end else begin
        low_byte  = code;
        want_high = 1'b1;
      end
      flags = flags >> 1;
    end
    // A byte that ends the stream always yields at least a bare marker.
    if (ends && run.size() == 0) run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
    if (run.size() > 0) begin
      run[run.size() - 1].run_last = 1'b1;
      run[run.size() - 1].done     = ends;
    end
    if (ends) restart_stream();
    if (keep) foreach (run[k]) decoded_q.push_back(run[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Picks an offset and a length: close behind the write position, around the
  // stream start, or anywhere in the ring.
  function automatic void pick_copy(output logic [11:0] src, output int unsigned span);
    span = $urandom_range(MIN_MATCH, MIN_MATCH + 15);
    case ($urandom_range(0, 3))
      0, 1:    src = wpos - 12'($urandom_range(1, 64));
      2:       src = RING_START + 12'($urandom_range(0, 40));
      default: src = 12'($urandom);
    endcase
  endfunction

  // Next compressed byte. Which kind of byte it is follows from the decoder state.
  function automatic logic [7:0] next_code();
    logic [11:0] src;
    int unsigned span;
    if (want_high) return held_high;
    if (flags_n == 0) begin
      case ($urandom_range(0, 5))
        0:       return 8'hFF;
        1:       return 8'h00;
        default: return 8'($urandom);
      endcase
    end
    if (flags[0]) return 8'($urandom);
    pick_copy(src, span);
    held_high = {src[11:8], 4'(span - MIN_MATCH)};
    return src[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------

  function automatic gap_phase_e cur_phase();
    return gap_phase_e'((n_sent / 48) % 4);
  endfunction

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_rests();
    case (cur_phase())
      PH_SEND_GAPS: return roll(72);
      PH_BOTH:      return roll(17);
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (cur_phase())
      PH_SINK_STALLS: return roll(72);
      PH_BOTH:        return roll(17);
      default:        return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Call at a falling edge. The task returns at the falling edge after the
  // transaction and leaves tvalid high, so that the next byte can follow at once.
  task automatic push_byte(input logic [7:0] code, input logic ends, input int n_typed,
                           input beat_t typed);
    while (sender_rests()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= ends;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    decode_token(code, ends, n_typed == FROM_PREDICTOR);
    if (n_typed == 1) decoded_q.push_back(typed);
    @(negedge clk);
  endtask

  // The sender pauses until every result it is owed has come back.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // One stream of n_items compressed bytes.
  task automatic feed_stream(input int unsigned n_items);
    logic [7:0]  code;
    logic        ends;
    int unsigned k;
    k = 0;
    do begin
      ends = (k + 1 == n_items);
      code = next_code();
      push_byte(code, ends, FROM_PREDICTOR, '0);
      k++;
    end while (!ends);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  always @(negedge clk) m_tready <= !sink_stalls();

  task automatic note_fault(input string what, input beat_t want, input beat_t got);
    faults++;
    if (faults <= 10)
      $display("%0t: %s: want byte %02h has %0b tlast %0b done %0b, %s", $time, what,
               want.data, want.has, want.run_last, want.done,
               $sformatf("got byte %02h has %0b tlast %0b done %0b",
                         got.data, got.has, got.run_last, got.done));
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
    if (rst_n && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        note_fault("result with nothing pending", '0, got);
      end else begin
        want = decoded_q.pop_front();
        if (got.data !== want.data || got.has !== want.has ||
            got.run_last !== want.run_last || got.done !== want.done)
          note_fault("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------------

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout with %0d results outstanding", decoded_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned len;
    restart_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r])
      push_byte(dir_rows[r].code, dir_rows[r].ends, dir_rows[r].n_typed,
                '{dir_rows[r].t_data, dir_rows[r].t_has, 1'b1, dir_rows[r].t_done});
    hold_until_drained();

    // Short random streams. Now and then the sender waits for a full drain.
    while (n_random < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      feed_stream(len);
      n_random += len;
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end
    s_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
